/* src/wgm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants of the wildcard glob matcher: request and
// result words, request codes and the two wildcard symbols.
// ----------------------------------------------------------------------------
package wgm_pkg;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_TEXT   = 2'd2,
    REQ_FINISH = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t   req_type;
    logic [7:0]  symbol;
  } req_word_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } rsp_word_t;

  localparam logic [7:0] SYM_STAR = 8'h2A;
  localparam logic [7:0] SYM_ANY  = 8'h3F;

endpackage

/* src/wgm_closure.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_closure
// Star closure of a live position vector: a live position whose propagate
// bit is set makes the next position live, repeated over runs of stars.
// Built as a parallel prefix network with log2(W) levels.
// ----------------------------------------------------------------------------
module wgm_closure #(
  parameter int unsigned W = 65
) (
  input  logic [W-1:0] base,
  input  logic [W-1:0] prop,
  output logic [W-1:0] live
);

  localparam int unsigned LVLS = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0] gen_l  [LVLS+1];
  logic [W-1:0] prop_l [LVLS+1];

  assign gen_l[0]  = base;
  assign prop_l[0] = prop;

  // prop[k] set means position k is reached from a live position k-1
  for (genvar l = 0; l < LVLS; l++) begin : g_lvl
    assign gen_l[l+1]  = gen_l[l] | (prop_l[l] & (gen_l[l] << (1 << l)));
    assign prop_l[l+1] = prop_l[l] & (prop_l[l] << (1 << l));
  end

  assign live = gen_l[LVLS];

endmodule

/* src/wgm_cells.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_cells
// Row of pattern cells. Each cell stores one pattern byte, decodes its
// wildcard kind and computes its share of the position advance on a text
// byte. Also gives the star mask of the stored pattern and of the pattern
// with the byte being appended.
// ----------------------------------------------------------------------------
module wgm_cells #(
  parameter int unsigned N = 64
) (
  input  logic                       clk,
  input  logic [$clog2(N+1)-1:0]     length,
  input  logic [N-1:0]               live,
  input  logic [7:0]                 symbol,
  input  logic                       wr_en,
  output logic [N-1:0]               star_mask,
  output logic [N-1:0]               star_append,
  output logic [N:0]                 adv_base
);

  localparam int unsigned LEN_W = $clog2(N+1);

  logic [7:0]   store [N];
  logic [N-1:0] used;
  logic [N-1:0] stay;
  logic [N-1:0] step;
  logic [N-1:0] wr_hit;
  logic         sym_is_star;

  assign sym_is_star = (symbol == wgm_pkg::SYM_STAR);

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic is_star;
    logic is_any;

    always_ff @(posedge clk) begin
      if (wr_hit[k]) begin
        store[k] <= symbol;
      end
    end

    assign wr_hit[k]      = wr_en && (length == LEN_W'(k));
    assign used[k]        = LEN_W'(k) < length;
    assign is_star        = (store[k] == wgm_pkg::SYM_STAR);
    assign is_any         = (store[k] == wgm_pkg::SYM_ANY);
    assign star_mask[k]   = used[k] && is_star;
    assign star_append[k] = star_mask[k] || (wr_hit[k] && sym_is_star);
    // a star keeps its position live, anything else steps on a match
    assign stay[k]        = live[k] && used[k] && is_star;
    assign step[k]        = live[k] && used[k] && !is_star &&
                            (is_any || (store[k] == symbol));
  end

  assign adv_base[0] = stay[0];
  for (genvar k = 1; k < N; k++) begin : g_adv
    assign adv_base[k] = stay[k] || step[k-1];
  end
  assign adv_base[N] = step[N-1];

endmodule

/* src/wildcard_glob_matcher_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_core
// Whole-string glob matcher with '?' and '*' over a pattern of up to
// PAT_MAX bytes.
// ----------------------------------------------------------------------------
// One request word is taken every clock cycle, with no gaps between clear,
// append, text and finish words. A word is registered on acceptance and
// executed from that register in the following cycle unless it waits; then
// every pattern position is updated at once and the star closure runs
// through a log2(PAT_MAX+1)-level prefix network, and a finish word's result
// is written to the result register. Only a finish word that meets a
// stalled result waits, and the request side stalls behind it.
module wildcard_glob_matcher_core #(
  parameter int unsigned PAT_MAX = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  wgm_pkg::req_word_t req_word,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output wgm_pkg::rsp_word_t rsp_word
);

  localparam int unsigned LEN_W = $clog2(PAT_MAX+1);

  logic               s1_valid;
  wgm_pkg::req_word_t s1_word;
  logic [LEN_W-1:0]   length;
  logic               ovf;
  logic [PAT_MAX:0]   live;

  logic               exec;
  logic               do_finish;
  logic               rsp_free;
  logic               has_room;
  logic               wr_en;
  logic [PAT_MAX-1:0] star_mask;
  logic [PAT_MAX-1:0] star_append;
  logic [PAT_MAX-1:0] star_sel;
  logic [PAT_MAX:0]   adv_base;
  logic [PAT_MAX:0]   base_sel;
  logic [PAT_MAX:0]   live_next;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign exec      = s1_valid && ((s1_word.req_type != wgm_pkg::REQ_FINISH) || rsp_free);
  assign do_finish = exec && (s1_word.req_type == wgm_pkg::REQ_FINISH);
  assign req_stall = s1_valid && !exec;
  assign has_room  = length < LEN_W'(PAT_MAX);
  assign wr_en     = exec && (s1_word.req_type == wgm_pkg::REQ_APPEND) && has_room;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s1_word <= req_word;
    end
  end

  wgm_cells #(
    .N (PAT_MAX)
  ) u_cells (
    .clk         (clk),
    .length      (length),
    .live        (live[PAT_MAX-1:0]),
    .symbol      (s1_word.symbol),
    .wr_en       (wr_en),
    .star_mask   (star_mask),
    .star_append (star_append),
    .adv_base    (adv_base)
  );

  // text words advance the vector, everything else restarts at position zero
  always_comb begin
    base_sel = (PAT_MAX+1)'(1);
    star_sel = star_mask;
    case (s1_word.req_type)
      wgm_pkg::REQ_CLEAR: begin
        star_sel = '0;
      end
      wgm_pkg::REQ_APPEND: begin
        star_sel = star_append;
      end
      wgm_pkg::REQ_TEXT: begin
        base_sel = adv_base;
      end
      default: begin
        star_sel = star_mask;
      end
    endcase
  end

  wgm_closure #(
    .W (PAT_MAX+1)
  ) u_closure (
    .base (base_sel),
    .prop ({star_sel, 1'b0}),
    .live (live_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      ovf    <= 1'b0;
      live   <= (PAT_MAX+1)'(1);
    end else if (exec) begin
      live <= live_next;
      case (s1_word.req_type)
        wgm_pkg::REQ_CLEAR: begin
          length <= '0;
          ovf    <= 1'b0;
        end
        wgm_pkg::REQ_APPEND: begin
          if (has_room) begin
            length <= length + LEN_W'(1);
          end else begin
            ovf <= 1'b1;
          end
        end
        default: begin
          length <= length;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid <= do_finish;
    end
  end

  always_ff @(posedge clk) begin
    if (do_finish) begin
      rsp_word.matched  <= live[length];
      rsp_word.overflow <= ovf;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(PAT_MAX))
    else $error("pattern length beyond capacity");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    ((live >> length) >> 1) == '0)
    else $error("live position beyond pattern end");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (length == LEN_W'(PAT_MAX)))
    else $error("overflow flagged with room in pattern");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    exec && (s1_word.req_type != wgm_pkg::REQ_TEXT) |=> live[0])
    else $error("position zero not live after restart");

  a_finish_rsp: assert property (@(posedge clk) disable iff (rst)
    do_finish |=> rsp_valid)
    else $error("finish word produced no result");

endmodule

/* tb/wgm_match_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_match_checker
// Watches both channels of the glob matcher. It tracks the pattern, the live
// pattern positions and the overflow flag for every accepted request word,
// queues the verdict of each finish word, and compares every accepted result
// word with the oldest queued verdict, field by field.
// ----------------------------------------------------------------------------
module wgm_match_checker #(
  parameter int unsigned PAT_MAX = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  wgm_pkg::req_word_t req_word,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  wgm_pkg::rsp_word_t rsp_word,
  output int unsigned        fail_count,
  output int unsigned        verdicts_pending
);

  logic [7:0]         pat_mem [PAT_MAX];
  int unsigned        pat_len;
  logic [PAT_MAX:0]   live;
  logic               dropped;
  wgm_pkg::rsp_word_t verdict_q [$];

  // a live star also makes the position after it live (empty run)
  function automatic logic [PAT_MAX:0] close_over_stars(logic [PAT_MAX:0] v);
    for (int unsigned j = 0; j < pat_len; j++) begin
      if (v[j] && pat_mem[j] == wgm_pkg::SYM_STAR) v[j+1] = 1'b1;
    end
    return v;
  endfunction

  function automatic logic [PAT_MAX:0] empty_text_positions();
    logic [PAT_MAX:0] v;
    v    = '0;
    v[0] = 1'b1;
    return close_over_stars(v);
  endfunction

  function automatic logic [PAT_MAX:0] consume_byte(logic [7:0] c);
    logic [PAT_MAX:0] nxt;
    nxt = '0;
    for (int unsigned j = 0; j < pat_len; j++) begin
      if (live[j]) begin
        if (pat_mem[j] == wgm_pkg::SYM_STAR) nxt[j] = 1'b1;
        else if (pat_mem[j] == wgm_pkg::SYM_ANY || pat_mem[j] == c) nxt[j+1] = 1'b1;
      end
    end
    return close_over_stars(nxt);
  endfunction

  always @(posedge clk) begin
    wgm_pkg::rsp_word_t want;
    wgm_pkg::rsp_word_t got;
    if (rst) begin
      pat_len    = 0;
      dropped    = 1'b0;
      live       = empty_text_positions();
      fail_count = 0;
      verdict_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        got = rsp_word;
        if (verdict_q.size() == 0) begin
          $display("%0t: result word with no finish pending: matched %b overflow %b",
                   $time, got.matched, got.overflow);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (got.matched !== want.matched) begin
            $display("%0t: matched mismatch: expected %b, actual %b",
                     $time, want.matched, got.matched);
            fail_count++;
          end
          if (got.overflow !== want.overflow) begin
            $display("%0t: overflow mismatch: expected %b, actual %b",
                     $time, want.overflow, got.overflow);
            fail_count++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        case (req_word.req_type)
          wgm_pkg::REQ_CLEAR: begin
            pat_len = 0;
            dropped = 1'b0;
            live    = empty_text_positions();
          end
          wgm_pkg::REQ_APPEND: begin
            if (pat_len < PAT_MAX) begin
              pat_mem[pat_len] = req_word.symbol;
              pat_len++;
            end else begin
              dropped = 1'b1;
            end
            live = empty_text_positions();
          end
          wgm_pkg::REQ_TEXT: begin
            live = consume_byte(req_word.symbol);
          end
          default: begin
            want.matched  = live[pat_len];
            want.overflow = dropped;
            verdict_q.push_back(want);
            live = empty_text_positions();
          end
        endcase
      end
    end
    verdicts_pending = verdict_q.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the glob matcher: a directed opening over the corner cases,
// then random patterns with texts built to match them (and some mutated or
// broken), with bursty request traffic and a stalling result side. A
// separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned PAT_MAX      = 64;
  localparam int unsigned TARGET_WORDS = 550;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  wgm_pkg::req_word_t req_word  = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  wgm_pkg::rsp_word_t rsp_word;

  int unsigned fail_count;
  int unsigned verdicts_pending;
  int unsigned words_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_mode  = 0;
  logic [7:0]  pat_mirror [$];
  logic [7:0]  text_buf [$];

  wildcard_glob_matcher_core #(
    .PAT_MAX(PAT_MAX)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_word (req_word),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_word (rsp_word)
  );

  wgm_match_checker #(
    .PAT_MAX(PAT_MAX)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req_word        (req_word),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .rsp_word        (rsp_word),
    .fail_count      (fail_count),
    .verdicts_pending(verdicts_pending)
  );

  always #5 clk = ~clk;

  // result side: free-flowing, light and heavy stall stretches
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       rsp_stall = 1'b0;
      1:       rsp_stall = ($urandom_range(0, 1) == 0);
      default: rsp_stall = ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[wildcard_glob_matcher_core] ERROR");
      $finish;
    end
  end

  // mostly a tiny alphabet so that patterns and texts interact
  function automatic logic [7:0] pick_symbol();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return "a";
    if (r < 60) return "b";
    if (r < 75) return wgm_pkg::SYM_STAR;
    if (r < 87) return wgm_pkg::SYM_ANY;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input wgm_pkg::req_kind_t kind, input logic [7:0] sym);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 16);
    end
    req_word.req_type = kind;
    req_word.symbol   = sym;
    req_valid         = 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    words_sent++;
  endtask

  task automatic drain_verdicts();
    req_valid = 1'b0;
    while (verdicts_pending != 0) @(negedge clk);
  endtask

  // text that fits the mirrored pattern, optionally broken afterwards
  task automatic build_text(input bit faithful);
    int unsigned k;
    text_buf.delete();
    foreach (pat_mirror[i]) begin
      if (pat_mirror[i] == wgm_pkg::SYM_STAR) begin
        repeat ($urandom_range(0, 3)) text_buf.push_back(pick_symbol());
      end else if (pat_mirror[i] == wgm_pkg::SYM_ANY) begin
        text_buf.push_back(pick_symbol());
      end else begin
        text_buf.push_back(pat_mirror[i]);
      end
    end
    if (!faithful) begin
      k = $urandom_range(0, 2);
      if (k == 0 || text_buf.size() == 0) text_buf.push_back(pick_symbol());
      else if (k == 1) text_buf.delete($urandom_range(0, text_buf.size() - 1));
      else text_buf[$urandom_range(0, text_buf.size() - 1)] = pick_symbol();
    end
  endtask

  task automatic run_sequence(input bit go_long);
    int unsigned plen;
    int unsigned ntext;
    int          cut;
    logic [7:0]  s;
    if (go_long || $urandom_range(0, 9) != 0) begin
      send_word(wgm_pkg::REQ_CLEAR, 8'($urandom_range(0, 255)));
      pat_mirror.delete();
    end
    if (go_long) plen = PAT_MAX + 2;
    else if ($urandom_range(0, 11) == 0) plen = $urandom_range(58, 70);
    else plen = $urandom_range(0, 8);
    repeat (plen) begin
      s = pick_symbol();
      send_word(wgm_pkg::REQ_APPEND, s);
      if (pat_mirror.size() < PAT_MAX) pat_mirror.push_back(s);
    end
    ntext = $urandom_range(1, 3);
    repeat (ntext) begin
      build_text($urandom_range(0, 3) != 0);
      // now and then the pattern grows while a text is streaming
      cut = ($urandom_range(0, 9) == 0 && text_buf.size() != 0) ?
            $urandom_range(0, text_buf.size() - 1) : -1;
      foreach (text_buf[i]) begin
        if (i == cut) begin
          s = pick_symbol();
          send_word(wgm_pkg::REQ_APPEND, s);
          if (pat_mirror.size() < PAT_MAX) pat_mirror.push_back(s);
        end
        send_word(wgm_pkg::REQ_TEXT, text_buf[i]);
      end
      send_word(wgm_pkg::REQ_FINISH, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_word(wgm_pkg::req_kind_t'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty pattern: empty text matches, anything else does not
    send_word(wgm_pkg::REQ_FINISH, 8'h00);
    send_word(wgm_pkg::REQ_TEXT, "a");
    send_word(wgm_pkg::REQ_FINISH, 8'hFF);
    // lone star swallows extreme bytes
    send_word(wgm_pkg::REQ_APPEND, wgm_pkg::SYM_STAR);
    send_word(wgm_pkg::REQ_TEXT, 8'hFF);
    send_word(wgm_pkg::REQ_TEXT, 8'h00);
    send_word(wgm_pkg::REQ_FINISH, 8'h00);
    // '?' takes a text '*' like any byte
    send_word(wgm_pkg::REQ_CLEAR, 8'hFF);
    send_word(wgm_pkg::REQ_APPEND, wgm_pkg::SYM_ANY);
    send_word(wgm_pkg::REQ_APPEND, "b");
    send_word(wgm_pkg::REQ_TEXT, wgm_pkg::SYM_STAR);
    send_word(wgm_pkg::REQ_TEXT, "b");
    send_word(wgm_pkg::REQ_FINISH, 8'h00);
    // text '?' is an ordinary byte
    send_word(wgm_pkg::REQ_CLEAR, 8'h00);
    send_word(wgm_pkg::REQ_APPEND, "a");
    send_word(wgm_pkg::REQ_TEXT, wgm_pkg::SYM_ANY);
    send_word(wgm_pkg::REQ_FINISH, 8'h00);
    // append mid-text restarts the text
    send_word(wgm_pkg::REQ_TEXT, "a");
    send_word(wgm_pkg::REQ_APPEND, "c");
    send_word(wgm_pkg::REQ_TEXT, "a");
    send_word(wgm_pkg::REQ_TEXT, "c");
    send_word(wgm_pkg::REQ_FINISH, 8'h00);
    drain_verdicts();

    // pattern full, extra bytes dropped
    run_sequence(1'b1);
    while (words_sent < TARGET_WORDS) begin
      run_sequence(1'b0);
      if ($urandom_range(0, 7) == 0) drain_verdicts();
    end

    drain_verdicts();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("[wildcard_glob_matcher_core] OK");
    end else begin
      $display("[wildcard_glob_matcher_core] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/wgm_pkg.sv
src/wgm_closure.sv
src/wgm_cells.sv
src/wildcard_glob_matcher_core.sv
tb/wgm_match_checker.sv
tb/testbench.sv
